>>> rtl/lua_pkg.sv
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the ID allocator.
package lua_pkg;

   localparam int unsigned NUM_IDS     = 64;
   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned ID_W        = $clog2(NUM_IDS);
   localparam int unsigned AREA_SHIFT  = 25;
   localparam int unsigned CSR_IDX_W   = 8;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_ROBIN    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELOC_ENABLE   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_LIMIT    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_START = 8'd3;

   typedef enum logic [1:0] {
      TGT_HOLD,
      TGT_RELEASE,
      TGT_ZERO,
      TGT_ROTATION
   } target_sel_type;

   typedef struct packed {
      logic           load_req;
      target_sel_type sel_target;
      logic           scan_start;
      logic           scan_issue;
      logic           read_target;
      logic           modify;
      logic           load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic granted;
      logic rr_mode;
      logic scan_last;
   } status_type;

endpackage

>>> rtl/lua_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lua_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lua_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the ID allocator.
module lua_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lua_pkg::status_type status,
   output lua_pkg::cmd_type    cmd
);
   import lua_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      DECIDE,
      SCAN,
      DRAIN,
      READ,
      MODIFY,
      RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.sel_target = TGT_HOLD;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = DECIDE;
            end
         end
         DECIDE: begin
            priority if (status.is_release) begin
               cmd.sel_target = TGT_RELEASE;
               state_in       = READ;
            end else if (!status.granted) begin
               cmd.sel_target = TGT_ZERO;
               state_in       = READ;
            end else if (status.rr_mode) begin
               cmd.sel_target = TGT_ROTATION;
               state_in       = READ;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = READ;
         end
         READ: begin
            cmd.read_target = 1'b1;
            state_in        = MODIFY;
         end
         MODIFY: begin
            cmd.modify = 1'b1;
            state_in   = RESPOND;
         end
         RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/lua_datapath.sv
`timescale 1ns / 1ps
// Use-count store, least-used scan, rotation pointer and configuration registers.
module lua_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  lua_pkg::cmd_type                 cmd,
   output lua_pkg::status_type              status,
   input  logic                             req_func,
   input  logic [31:0]                      req_stack_address,
   input  logic                             req_is_current,
   input  logic [5:0]                       req_release_id,
   output logic [5:0]                       rsp_id_number,
   output logic [30:0]                      rsp_relocation_base,
   output logic                             rsp_load_register,
   output logic                             rsp_release_error,
   input  logic                             csr_valid,
   input  logic [lua_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_data
);
   import lua_pkg::*;

   // Configuration registers.
   logic        rr_mode_ff;
   logic        reloc_en_ff;
   logic [31:0] stack_limit_ff;
   logic [5:0]  rot_start_ff;

   // Latched request word.
   logic        func_ff;
   logic [31:0] addr_ff;
   logic        cur_ff;
   logic [5:0]  rel_ff;

   logic [ID_W-1:0]        target_ff, target_in;
   logic [COUNT_WIDTH-1:0] best_cnt_ff, best_cnt_in;
   logic [ID_W-1:0]        scan_ptr_ff;
   logic                   cmp_pend_ff;
   logic [ID_W-1:0]        cmp_id_ff;
   logic [ID_W-1:0]        next_rot_ff, next_rot_in;
   logic [NUM_IDS-1:0]     valid_ff;
   logic                   rd_valid_ff;

   logic       hold_load_ff;
   logic       hold_err_ff;
   logic [5:0] hold_id_ff;

   logic [5:0] rsp_id_ff;
   logic       rsp_load_ff;
   logic       rsp_err_ff;

   logic                   rd_en;
   logic [ID_W-1:0]        rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] cnt;
   logic                   wr_en;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   rel_in_range;
   logic                   rel_ok;
   logic                   start_ok;
   logic [ID_W-1:0]        eff_start;

   assign rel_in_range = 32'(rel_ff) < NUM_IDS;
   assign start_ok     = (rot_start_ff != 6'd0) && (32'(rot_start_ff) < NUM_IDS);
   assign eff_start    = start_ok ? ID_W'(rot_start_ff) : ID_W'(1);

   assign status.is_release = func_ff;
   assign status.granted    = reloc_en_ff && (addr_ff <= stack_limit_ff);
   assign status.rr_mode    = rr_mode_ff;
   assign status.scan_last  = (scan_ptr_ff == ID_W'(NUM_IDS - 1));

   assign rd_en   = cmd.scan_issue || cmd.read_target;
   assign rd_addr = cmd.scan_issue ? scan_ptr_ff : target_ff;
   assign cnt     = rd_valid_ff ? rd_data : '0;
   assign rel_ok  = rel_in_range && (cnt != '0);

   always_comb begin
      wr_en   = 1'b0;
      wr_data = cnt + COUNT_WIDTH'(1);
      if (cmd.modify) begin
         if (func_ff) begin
            wr_en   = rel_ok;
            wr_data = cnt - COUNT_WIDTH'(1);
         end else begin
            wr_en = (cnt != COUNT_MAX);
         end
      end
   end

   always_comb begin
      target_in   = target_ff;
      best_cnt_in = best_cnt_ff;
      next_rot_in = next_rot_ff;
      unique case (cmd.sel_target)
         TGT_HOLD: begin
            if (cmp_pend_ff && ((cmp_id_ff == ID_W'(1)) || (cnt < best_cnt_ff))) begin
               target_in   = cmp_id_ff;
               best_cnt_in = cnt;
            end
         end
         TGT_RELEASE: begin
            target_in = ID_W'(rel_ff);
         end
         TGT_ZERO: begin
            target_in = '0;
         end
         TGT_ROTATION: begin
            target_in = next_rot_ff;
            if (next_rot_ff == ID_W'(NUM_IDS - 1)) begin
               next_rot_in = eff_start;
            end else begin
               next_rot_in = next_rot_ff + ID_W'(1);
            end
         end
         default: begin
            target_in = target_ff;
         end
      endcase
   end

   lua_ram #(
      .WIDTH(COUNT_WIDTH),
      .DEPTH(NUM_IDS)
   ) u_counts (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(target_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_mode_ff     <= 1'b0;
         reloc_en_ff    <= 1'b1;
         stack_limit_ff <= 32'h0200_0000;
         rot_start_ff   <= 6'd1;
         next_rot_ff    <= ID_W'(1);
         valid_ff       <= '0;
         cmp_pend_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ROUND_ROBIN:    rr_mode_ff     <= csr_data[0];
               CSR_RELOC_ENABLE:   reloc_en_ff    <= csr_data[0];
               CSR_STACK_LIMIT:    stack_limit_ff <= csr_data;
               CSR_ROTATION_START: rot_start_ff   <= csr_data[5:0];
               default: begin
               end
            endcase
         end
         next_rot_ff <= next_rot_in;
         cmp_pend_ff <= cmd.scan_issue;
         if (wr_en) begin
            valid_ff[target_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         addr_ff <= req_stack_address;
         cur_ff  <= req_is_current;
         rel_ff  <= req_release_id;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.scan_start) begin
         scan_ptr_ff <= ID_W'(1);
      end else if (cmd.scan_issue) begin
         scan_ptr_ff <= scan_ptr_ff + ID_W'(1);
      end
      cmp_id_ff   <= scan_ptr_ff;
      target_ff   <= target_in;
      best_cnt_ff <= best_cnt_in;
      if (cmd.modify) begin
         hold_id_ff   <= func_ff ? 6'd0 : 6'(target_ff);
         hold_load_ff <= func_ff ? 1'b1 : cur_ff;
         hold_err_ff  <= func_ff ? !rel_ok : 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_id_ff   <= hold_id_ff;
         rsp_load_ff <= hold_load_ff;
         rsp_err_ff  <= hold_err_ff;
      end
   end

   assign rsp_id_number       = rsp_id_ff;
   assign rsp_relocation_base = {rsp_id_ff, {AREA_SHIFT{1'b0}}};
   assign rsp_load_register   = rsp_load_ff;
   assign rsp_release_error   = rsp_err_ff;

endmodule

>>> rtl/least_used_id_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the least-used address-space ID allocator.
// A least-used allocation runs a scan that reads one use count per cycle from the count RAM.
// Releases, rotation allocations and allocations of ID zero skip the scan.
// One word is in work at a time; the next is accepted the cycle after a result is posted,
// even while that result waits.
// Reset clears all use counts, sets the rotation pointer to 1 and loads the register defaults.
module least_used_id_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [31:0]                   req_stack_address,
   input  logic                          req_is_current,
   input  logic [5:0]                    req_release_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [5:0]                    rsp_id_number,
   output logic [30:0]                   rsp_relocation_base,
   output logic                          rsp_load_register,
   output logic                          rsp_release_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lua_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import lua_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lua_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   lua_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_func),
      .req_stack_address  (req_stack_address),
      .req_is_current     (req_is_current),
      .req_release_id     (req_release_id),
      .rsp_id_number      (rsp_id_number),
      .rsp_relocation_base(rsp_relocation_base),
      .rsp_load_register  (rsp_load_register),
      .rsp_release_error  (rsp_release_error),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

endmodule

>>> verif/least_used_id_allocator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the least-used ID allocator with a model of counts and rotation.
module least_used_id_allocator_top_tb;
   import lua_pkg::*;

   localparam logic FUNC_ALLOCATE = 1'b0;
   localparam logic FUNC_RELEASE  = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 8'hA5;
   localparam int unsigned IDLE_PCT      = 38;
   localparam int unsigned SETTLE_CYCLES = 2 * (NUM_IDS + 4);
   localparam longint unsigned RUN_LIMIT_NS = 64'd30_000_000;

   typedef struct {
      logic            func;
      logic [31:0]     stack_address;
      logic            is_current;
      logic [ID_W-1:0] release_id;
   } req_word_type;

   typedef struct {
      logic [ID_W-1:0] id_number;
      logic [30:0]     relocation_base;
      logic            load_register;
      logic            release_error;
   } grant_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_func = 1'b0;
   logic [31:0]          req_stack_address = '0;
   logic                 req_is_current = 1'b0;
   logic [ID_W-1:0]      req_release_id = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ID_W-1:0]      rsp_id_number;
   logic [30:0]          rsp_relocation_base;
   logic                 rsp_load_register;
   logic                 rsp_release_error;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   // Model state and its copy of the registers.
   logic [COUNT_WIDTH-1:0] use_count [NUM_IDS];
   logic [ID_W-1:0]        next_rotation = 1;
   logic                   rotate_mode = 1'b0;
   logic                   relocation_on = 1'b1;
   logic [31:0]            stack_ceiling = 32'h0200_0000;
   logic [ID_W-1:0]        rotation_first = 1;

   req_word_type req_words_pending [$];
   grant_type    grants_due [$];
   bit          req_taken = 1'b0;
   int unsigned idle_pct = IDLE_PCT;
   int unsigned hold_cycles = 0;
   int unsigned items_queued = 0;
   int unsigned grants_checked = 0;
   int unsigned mismatches = 0;
   int unsigned phases = 0;
   int unsigned allocations = 0;
   int unsigned zero_grants = 0;
   int unsigned fallback_picks = 0;
   int unsigned releases = 0;
   int unsigned release_faults = 0;

   least_used_id_allocator_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_stack_address   (req_stack_address),
      .req_is_current      (req_is_current),
      .req_release_id      (req_release_id),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_id_number       (rsp_id_number),
      .rsp_relocation_base (rsp_relocation_base),
      .rsp_load_register   (rsp_load_register),
      .rsp_release_error   (rsp_release_error),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic grant_type compute_grant(input req_word_type w);
      grant_type       g;
      int unsigned     chosen;
      int unsigned     best;
      int unsigned     i;
      bit              found;
      logic [ID_W-1:0] wrap_id;
      g.id_number       = '0;
      g.relocation_base = '0;
      g.load_register   = 1'b1;
      g.release_error   = 1'b1;
      if (w.func == FUNC_RELEASE) begin
         releases++;
         if (use_count[w.release_id] != '0) begin
            use_count[w.release_id] = use_count[w.release_id] - 1'b1;
            g.release_error = 1'b0;
         end else begin
            release_faults++;
         end
         return g;
      end
      allocations++;
      chosen = 0;
      if (relocation_on && w.stack_address <= stack_ceiling) begin
         if (rotate_mode) begin
            wrap_id = (rotation_first == '0) ? ID_W'(1) : rotation_first;
            chosen = next_rotation;
            next_rotation = (chosen == NUM_IDS - 1) ? wrap_id : ID_W'(chosen + 1);
         end else begin
            best = 1;
            found = 1'b0;
            for (i = 1; i < NUM_IDS; i++) begin
               if (!found) begin
                  if (use_count[i] == '0) begin
                     chosen = i;
                     found = 1'b1;
                  end else if (use_count[best] > use_count[i]) begin
                     best = i;
                  end
               end
            end
            if (!found) begin
               chosen = best;
               fallback_picks++;
            end
         end
      end
      if (chosen == 0) zero_grants++;
      if (use_count[chosen] != COUNT_MAX) use_count[chosen] = use_count[chosen] + 1'b1;
      g.id_number       = ID_W'(chosen);
      g.relocation_base = 31'(chosen) << AREA_SHIFT;
      g.load_register   = w.is_current;
      g.release_error   = 1'b0;
      return g;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] index, input logic [31:0] data);
      case (index)
         CSR_ROUND_ROBIN:    rotate_mode    = data[0];
         CSR_RELOC_ENABLE:   relocation_on  = data[0];
         CSR_STACK_LIMIT:    stack_ceiling  = data;
         CSR_ROTATION_START: rotation_first = data[ID_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want) report_mismatch($sformatf("%s is 0x%0h, model gives 0x%0h", name, got, want));
   endtask

   always @(negedge clock) begin : drive_requests
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_words_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
            w = req_words_pending.pop_front();
            req_valid         <= 1'b1;
            req_func          <= w.func;
            req_stack_address <= w.stack_address;
            req_is_current    <= w.is_current;
            req_release_id    <= w.release_id;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles != 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : watch_ports
      grant_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (grants_due.size() == 0) begin
               report_mismatch("result word with no request outstanding");
            end else begin
               want = grants_due.pop_front();
               check_field("id_number", rsp_id_number, want.id_number);
               check_field("relocation_base", rsp_relocation_base, want.relocation_base);
               check_field("load_register", rsp_load_register, want.load_register);
               check_field("release_error", rsp_release_error, want.release_error);
               grants_checked++;
            end
         end
         if (req_valid && req_ready) begin
            grants_due.push_back(compute_grant('{req_func, req_stack_address,
                                                 req_is_current, req_release_id}));
            req_taken = 1'b1;
         end
      end
   end

   task automatic push_word(input req_word_type w);
      req_words_pending.push_back(w);
      items_queued++;
   endtask

   function automatic req_word_type random_word(input int unsigned alloc_pct);
      req_word_type w;
      w.func       = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOCATE : FUNC_RELEASE;
      w.is_current = 1'($urandom);
      w.release_id = ($urandom_range(1) != 0) ? ID_W'($urandom_range(15)) : ID_W'($urandom);
      case ($urandom_range(5))
         0: w.stack_address = stack_ceiling;
         1: w.stack_address = stack_ceiling + 32'd1;
         5: w.stack_address = $urandom;
         default: w.stack_address = $urandom_range(stack_ceiling);
      endcase
      return w;
   endfunction

   task automatic wait_drained();
      while (grants_checked != items_queued) @(negedge clock);
   endtask

   task automatic configure(input logic rr, input logic en, input logic [31:0] limit,
                            input logic [31:0] start, input bit stray);
      logic [CSR_IDX_W-1:0] idx [$];
      logic [31:0]          dat [$];
      idx = '{CSR_ROUND_ROBIN, CSR_RELOC_ENABLE, CSR_STACK_LIMIT, CSR_ROTATION_START};
      dat = '{{31'($urandom), rr}, {31'($urandom), en}, limit, start};
      if (stray) begin
         idx.push_front(CSR_UNMAPPED);
         dat.push_front($urandom);
      end
      foreach (idx[k]) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= dat[k];
         do @(posedge clock); while (!csr_ready);
         apply_csr(idx[k], dat[k]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      phases++;
   endtask

   task automatic run_phase(input logic rr, input logic en, input logic [31:0] limit,
                            input logic [31:0] start, input int unsigned count,
                            input int unsigned alloc_pct, input int unsigned idle,
                            input int unsigned hold, input bit stray);
      configure(rr, en, limit, start, stray);
      @(posedge clock);
      idle_pct = idle;
      hold_cycles = hold;
      repeat (count) push_word(random_word(alloc_pct));
      wait_drained();
   endtask

   initial begin
      foreach (use_count[i]) use_count[i] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      push_word('{FUNC_ALLOCATE, 32'h0000_0000, 1'b1, 6'd0});
      push_word('{FUNC_ALLOCATE, 32'h0200_0000, 1'b0, 6'd63});
      push_word('{FUNC_ALLOCATE, 32'h0200_0001, 1'b1, 6'd0});
      push_word('{FUNC_ALLOCATE, 32'hFFFF_FFFF, 1'b0, 6'd63});
      push_word('{FUNC_RELEASE, 32'h0000_0000, 1'b0, 6'd1});
      push_word('{FUNC_RELEASE, 32'hFFFF_FFFF, 1'b1, 6'd1});
      push_word('{FUNC_RELEASE, 32'h0000_0000, 1'b0, 6'd63});
      push_word('{FUNC_RELEASE, 32'h5555_5555, 1'b1, 6'd0});
      push_word('{FUNC_ALLOCATE, 32'h0123_4567, 1'b1, 6'd42});
      push_word('{FUNC_RELEASE, 32'hAAAA_AAAA, 1'b0, 6'd2});
      push_word('{FUNC_RELEASE, 32'hFFFF_FFFF, 1'b1, 6'd42});
      wait_drained();

      run_phase(1'b0, 1'b1, 32'h0200_0000, 32'd1, 300, 85, IDLE_PCT, 0, 1'b1);
      run_phase(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd63, 150, 50, IDLE_PCT, 600, 1'b0);
      run_phase(1'b1, 1'b1, $urandom, 32'd63, 100, 90, IDLE_PCT, 0, 1'b0);
      run_phase(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFC0, 100, 80, IDLE_PCT, 0, 1'b0);
      run_phase(1'b1, 1'b1, 32'h0200_0000, $urandom_range(62, 2), 150, 70, IDLE_PCT, 0,
                1'b1);
      run_phase(1'b0, 1'b0, $urandom, 32'd1, 50, 70, IDLE_PCT, 0, 1'b0);
      run_phase(1'b0, 1'b1, 32'h0000_0000, 32'd1, 100, 60, IDLE_PCT, 0, 1'b0);
      run_phase(1'b0, 1'b1, $urandom, $urandom_range(63, 1), 100, 65, 0, 0, 1'b0);

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Covered %0d allocations (%0d of ID zero, %0d least-count fallbacks)",
               allocations, zero_grants, fallback_picks);
      $display("and %0d releases (%0d with an error) over %0d register setups.",
               releases, release_faults, phases);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("Timed out with %0d results still outstanding.", items_queued - grants_checked);
      $display("Mismatches found");
      $finish;
   end

endmodule
